[src/skt_pkg.sv]
// Shared types and codes for the sorted key table.
// No dependencies; imported by skt_cell and sorted_key_table_core.
package skt_pkg;

    localparam int KeyW = 32;
    localparam int IdxW = 6;
    localparam int OutW = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_DUP   = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [IdxW-1:0] index;
        logic            ins_apply;
        logic            rem_apply;
    } t_cell_ctl;

endpackage

[src/sorted_key_table_core.sv]
// Sorted key table: a row of cells that keeps unsigned keys in ascending order.
// A result beat is registered in the output register once the row has worked on its command.
// A new command is taken only after the row has worked on the held one, which waits while the output register is full.
// Reset clears the key count, the duplicate setting and both handshakes.
// Stored keys are not cleared; slots at or above the count are never read.
// Depends on skt_pkg and skt_cell.
module sorted_key_table_core
    import skt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // Command channel.
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_command,
    input  logic [KeyW-1:0] i_key,
    input  logic [IdxW-1:0] i_index,
    // Configuration register: allow_duplicates.
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    // Result channel.
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [KeyW-1:0] o_value,
    output logic [OutW-1:0] o_position,
    output logic [OutW-1:0] o_count,
    output logic [1:0]      o_status
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // The command register holds one accepted beat; the row works on it once
    // the output register is free or being emptied, and the result lands in the output register.
    logic            r_busy;
    logic [1:0]      r_cmd;
    logic [KeyW-1:0] r_key;
    logic [IdxW-1:0] r_index;
    logic [CW-1:0]   r_used;
    logic            r_allow;

    logic            r_out_valid;
    logic [KeyW-1:0] r_value;
    logic [OutW-1:0] r_position;
    logic [OutW-1:0] r_count;
    logic [1:0]      r_status;

    logic            in_fire;
    logic            compute;
    t_cell_ctl       ctl;

    logic [CAPACITY:0]   lt_chain;
    logic [CAPACITY-1:0] bound_vec;
    logic [CAPACITY-1:0] hit_vec;
    logic [KeyW-1:0]     ent [CAPACITY];
    logic [KeyW-1:0]     rd  [CAPACITY];

    logic [IW-1:0]   enc;
    logic [KeyW-1:0] rd_or;
    logic [CW-1:0]   pos;
    logic            full;
    logic            dup;
    logic            in_range;
    logic            do_ins;
    logic            do_rem;

    logic [CW-1:0]      n_used;
    logic [KeyW-1:0]    n_value;
    logic [CW-1:0]      n_pos;
    logic [1:0]         n_status;
    logic [CW+OutW-1:0] pos_wide;
    logic [CW+OutW-1:0] cnt_wide;

    assign o_in_ready = !r_busy;
    assign in_fire    = i_in_valid && !r_busy;
    // The row only works when the output register is free or being emptied.
    assign compute    = r_busy && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // Decisions taken from the cell flags.
    // ------------------------------------------------------------------
    always_comb begin
        enc   = '0;
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (bound_vec[i]) begin
                enc = enc | IW'(i);
            end
            rd_or = rd_or | rd[i];
        end
    end

    // With every stored key below the new one and the row full, the less-than
    // chain runs out past the last cell, no cell claims the insertion point,
    // and it sits at the end of the table.
    assign pos      = lt_chain[CAPACITY] ? CW'(CAPACITY) : CW'(enc);
    assign full     = r_used == CW'(CAPACITY);
    // A duplicate is checked ahead of the full condition.
    assign dup      = (|hit_vec) && !r_allow;
    assign in_range = {{CW{1'b0}}, r_index} < {{IdxW{1'b0}}, r_used};
    assign do_ins   = compute && (r_cmd == CMD_INSERT) && !dup && !full;
    assign do_rem   = compute && (r_cmd == CMD_REMOVE) && in_range;

    assign ctl.key       = r_key;
    assign ctl.index     = r_index;
    assign ctl.ins_apply = do_ins;
    assign ctl.rem_apply = do_rem;

    // ------------------------------------------------------------------
    // Cell row. Each cell sees its lower neighbor for inserts and its
    // upper neighbor for removals.
    // ------------------------------------------------------------------
    assign lt_chain[0] = 1'b1;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KeyW-1:0] prev_entry;
        logic [KeyW-1:0] next_entry;

        if (g == 0) begin : g_first
            assign prev_entry = r_key;
        end else begin : g_mid
            assign prev_entry = ent[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_entry = ent[g];
        end else begin : g_inner
            assign next_entry = ent[g+1];
        end

        skt_cell #(
            .IW (IW),
            .CW (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_used       (r_used),
            .i_slot       (IW'(g)),
            .i_prev_entry (prev_entry),
            .i_prev_lt    (lt_chain[g]),
            .i_next_entry (next_entry),
            .o_entry      (ent[g]),
            .o_lt         (lt_chain[g+1]),
            .o_bound      (bound_vec[g]),
            .o_hit        (hit_vec[g]),
            .o_read       (rd[g])
        );
    end

    // ------------------------------------------------------------------
    // Result of the command in the command register.
    // ------------------------------------------------------------------
    always_comb begin
        n_used   = r_used;
        n_value  = '0;
        n_pos    = '0;
        n_status = ST_OK;
        unique case (r_cmd)
            CMD_INSERT: begin
                n_pos = pos;
                if (dup) begin
                    n_status = ST_DUP;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_used = r_used + 1'b1;
                end
            end
            CMD_READ, CMD_REMOVE: begin
                if (in_range) begin
                    n_value = rd_or;
                    if (r_cmd == CMD_REMOVE) begin
                        n_used = r_used - 1'b1;
                    end
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                // The unused command code leaves everything as it is.
            end
        endcase
    end

    // Positions and counts are reported in seven bits whatever the capacity.
    assign pos_wide = {{OutW{1'b0}}, n_pos};
    assign cnt_wide = {{OutW{1'b0}}, n_used};

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_used      <= '0;
            r_allow     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_allow <= i_cfg_wdata;
            end
            if (compute) begin
                r_busy      <= 1'b0;
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else begin
                if (in_fire) begin
                    r_busy <= 1'b1;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd   <= i_command;
            r_key   <= i_key;
            r_index <= i_index;
        end
        if (compute) begin
            r_value    <= n_value;
            r_position <= pos_wide[OutW-1:0];
            r_count    <= cnt_wide[OutW-1:0];
            r_status   <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_position  = r_position;
    assign o_count     = r_count;
    assign o_status    = r_status;

endmodule

[src/skt_cell.sv]
// One slot of the sorted key table: holds a key and shifts with its neighbors.
// Depends on skt_pkg.
module skt_cell
    import skt_pkg::*;
#(
    parameter int IW = 6,
    parameter int CW = 7
) (
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  logic [CW-1:0]   i_used,
    input  logic [IW-1:0]   i_slot,
    input  logic [KeyW-1:0] i_prev_entry,
    input  logic            i_prev_lt,
    input  logic [KeyW-1:0] i_next_entry,
    output logic [KeyW-1:0] o_entry,
    output logic            o_lt,
    output logic            o_bound,
    output logic            o_hit,
    output logic [KeyW-1:0] o_read
);

    logic [KeyW-1:0] r_entry;
    logic [KeyW-1:0] n_entry;
    logic            slot_valid;
    logic            eq;
    logic            sel;
    logic            at_or_above;

    assign slot_valid  = {{CW{1'b0}}, i_slot} < {{IW{1'b0}}, i_used};
    assign o_lt        = slot_valid && (r_entry < i_ctl.key);
    assign eq          = slot_valid && (r_entry == i_ctl.key);
    // The first slot whose key is not below the new key is the insertion point.
    assign o_bound     = !o_lt && i_prev_lt;
    assign o_hit       = o_bound && eq;
    assign sel         = {{IdxW{1'b0}}, i_slot} == {{IW{1'b0}}, i_ctl.index};
    assign at_or_above = {{IdxW{1'b0}}, i_slot} >= {{IW{1'b0}}, i_ctl.index};
    assign o_read      = sel ? r_entry : '0;
    assign o_entry     = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_apply && !o_lt) begin
            n_entry = i_prev_lt ? i_ctl.key : i_prev_entry;
        end else if (i_ctl.rem_apply && at_or_above) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_key_table_core: directed rows, then random phases.
// Depends on skt_pkg and the core RTL; expected replies come from a local table model.
module tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int PHASE_ITEMS   = 200;
    localparam int NUM_PHASES    = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 8;

    // Command code 3 is unused by the core and must act as a no-op.
    localparam logic [1:0] CMD_NOP  = 2'd3;
    // Directed rows: no register write before the row.
    localparam logic [1:0] CFG_KEEP = 2'd2;

    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} t_phase_mix;

    typedef struct packed {
        logic [KeyW-1:0] value;
        logic [OutW-1:0] position;
        logic [OutW-1:0] count;
        logic [1:0]      status;
    } t_table_result;

    typedef struct packed {
        logic [1:0]      cfg;
        logic [1:0]      cmd;
        logic [KeyW-1:0] key;
        logic [IdxW-1:0] idx;
        logic            typed;
        t_table_result   res;
    } t_dir_row;

    localparam t_table_result NO_RES = '0;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic [1:0]      i_command;
    logic [KeyW-1:0] i_key;
    logic [IdxW-1:0] i_index;
    logic            i_cfg_we;
    logic            i_cfg_wdata;
    logic            o_out_valid;
    logic            i_out_ready;
    logic [KeyW-1:0] o_value;
    logic [OutW-1:0] o_position;
    logic [OutW-1:0] o_count;
    logic [1:0]      o_status;

    sorted_key_table_core #(
        .CAPACITY(TABLE_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_key      (i_key),
        .i_index    (i_index),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_value    (o_value),
        .o_position (o_position),
        .o_count    (o_count),
        .o_status   (o_status)
    );

    // Local copy of the table contents and the duplicate setting.
    logic [KeyW-1:0] key_store [TABLE_DEPTH];
    int              key_count;
    logic            dup_ok;

    t_table_result   table_replies [$];
    int              error_count;
    int              cycle_count;
    int              burst_left;
    bit              hold_request;
    int              n_insert, n_read, n_remove, n_nop;
    int              n_ok, n_full, n_dup, n_range;

    // Directed rows. Typed replies are the ones that are obvious from an empty table
    // and the error codes; the rest are predicted.
    t_dir_row dir_rows [22] = '{
        '{2'd0,     CMD_READ,   32'h0000_0000, 6'd0,  1'b1, '{32'h0, 7'd0, 7'd0, ST_RANGE}},
        '{CFG_KEEP, CMD_REMOVE, 32'h0000_0000, 6'd63, 1'b1, '{32'h0, 7'd0, 7'd0, ST_RANGE}},
        '{CFG_KEEP, CMD_NOP,    32'hFFFF_FFFF, 6'd63, 1'b1, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{CFG_KEEP, CMD_INSERT, 32'h0000_0000, 6'd0,  1'b1, '{32'h0, 7'd0, 7'd1, ST_OK}},
        '{CFG_KEEP, CMD_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b1, '{32'h0, 7'd1, 7'd2, ST_OK}},
        '{CFG_KEEP, CMD_INSERT, 32'h0000_0000, 6'd0,  1'b1, '{32'h0, 7'd0, 7'd2, ST_DUP}},
        '{CFG_KEEP, CMD_INSERT, 32'hFFFF_FFFF, 6'd63, 1'b1, '{32'h0, 7'd1, 7'd2, ST_DUP}},
        '{CFG_KEEP, CMD_INSERT, 32'h8000_0000, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_INSERT, 32'h5555_5555, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_INSERT, 32'hAAAA_AAAA, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_READ,   32'h0000_0000, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_READ,   32'hFFFF_FFFF, 6'd4,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_READ,   32'h0000_0000, 6'd5,  1'b0, NO_RES},
        '{2'd1,     CMD_INSERT, 32'h0000_0000, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_INSERT, 32'h5555_5555, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_READ,   32'h0000_0000, 6'd1,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_REMOVE, 32'h0000_0000, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_REMOVE, 32'h0000_0000, 6'd6,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_REMOVE, 32'h0000_0000, 6'd63, 1'b0, NO_RES},
        '{2'd0,     CMD_INSERT, 32'h7FFF_FFFF, 6'd0,  1'b0, NO_RES},
        '{CFG_KEEP, CMD_READ,   32'h0000_0000, 6'd42, 1'b0, NO_RES}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one command to the local table and return the reply the core owes.
    function automatic t_table_result table_apply(input logic [1:0] cmd,
                                                  input logic [KeyW-1:0] key,
                                                  input logic [IdxW-1:0] idx);
        t_table_result r;
        int lo, hi, mid, slot;
        r = '0;
        if (cmd == CMD_INSERT) begin
            // Lowest slot holding a key >= the new one, so equal keys go in front.
            lo = 0;
            hi = key_count;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (key_store[mid] < key) lo = mid + 1;
                else hi = mid;
            end
            r.position = 7'(lo);
            if (lo < key_count && key_store[lo] == key && !dup_ok) begin
                r.status = ST_DUP;
            end else if (key_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (slot = key_count; slot > lo; slot--) key_store[slot] = key_store[slot - 1];
                key_store[lo] = key;
                key_count++;
            end
        end else if (cmd == CMD_READ || cmd == CMD_REMOVE) begin
            if (int'(idx) < key_count) begin
                r.value = key_store[idx];
                if (cmd == CMD_REMOVE) begin
                    for (slot = idx; slot + 1 < key_count; slot++) key_store[slot] = key_store[slot + 1];
                    key_count--;
                end
            end else begin
                r.status = ST_RANGE;
            end
        end
        r.count = 7'(key_count);
        return r;
    endfunction

    // Random key: a narrow band and near neighbors of stored keys make duplicates common.
    function automatic logic [KeyW-1:0] pick_key();
        int r;
        logic [KeyW-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 35) return KeyW'($urandom_range(0, 127));
        if (r < 55 && key_count > 0) begin
            k = key_store[$urandom_range(0, key_count - 1)];
            case ($urandom_range(0, 2))
                0: return k;
                1: return k + 1;
                default: return k - 1;
            endcase
        end
        if (r < 85) return $urandom;
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return KeyW'(1);
            default: return 32'hFFFF_FFFE;
        endcase
    endfunction

    // Random index: mostly live slots with the ends favored, sometimes anywhere.
    function automatic logic [IdxW-1:0] pick_index();
        if (key_count > 0 && $urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return IdxW'(key_count - 1);
                default: return IdxW'($urandom_range(0, key_count - 1));
            endcase
        end
        return IdxW'($urandom_range(0, TABLE_DEPTH - 1));
    endfunction

    // Present one command beat at the current falling edge and hold it until accepted.
    task automatic send_command(input logic [1:0] cmd, input logic [KeyW-1:0] key,
                                input logic [IdxW-1:0] idx, input logic typed,
                                input t_table_result typed_res);
        t_table_result predicted;
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_key      = key;
        i_index    = idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = table_apply(cmd, key, idx);
        table_replies.push_back(typed ? typed_res : predicted);
        case (cmd)
            CMD_INSERT: n_insert++;
            CMD_READ:   n_read++;
            CMD_REMOVE: n_remove++;
            default:    n_nop++;
        endcase
        @(negedge i_clk);
    endtask

    // Bursts of random length separated by random gaps; some bursts are long.
    task automatic sender_pause();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 25);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // The register is only written once every reply has come back.
    task automatic write_dup(input logic v);
        i_in_valid = 1'b0;
        while (table_replies.size() != 0) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        dup_ok      = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Reply monitor: every accepted beat is matched against the oldest expectation.
    always @(posedge i_clk) begin : reply_check
        t_table_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            case (o_status)
                ST_OK:   n_ok++;
                ST_FULL: n_full++;
                ST_DUP:  n_dup++;
                default: n_range++;
            endcase
            if (table_replies.size() == 0) begin
                error_count++;
                $display("%0t: reply beat with nothing expected, got value %0h status %0d",
                         $time, o_value, o_status);
            end else begin
                want = table_replies.pop_front();
                check_field("value",    want.value,    o_value);
                check_field("position", 32'(want.position), 32'(o_position));
                check_field("count",    32'(want.count),    32'(o_count));
                check_field("status",   32'(want.status),   32'(o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d replies outstanding",
                     cycle_count, table_replies.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: stall patterns picked at random in turn, plus one long
    // hold-off on request, counted here so the sender keeps offering beats meanwhile.
    initial begin : reply_sink
        int mode, mode_left, hold_left;
        i_out_ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = 1'($urandom_range(0, 1));
                    2: i_out_ready = (mode_left % 3) != 0;
                    default: i_out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int row, phase, item, pick;
        t_phase_mix mix;
        logic [1:0] cmd;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_INSERT;
        i_key        = '0;
        i_index      = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        hold_request = 1'b0;
        key_count    = 0;
        dup_ok       = 1'b0;
        error_count  = 0;
        cycle_count  = 0;
        burst_left   = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (row = 0; row < $size(dir_rows); row++) begin
            if (dir_rows[row].cfg != CFG_KEEP) write_dup(dir_rows[row].cfg[0]);
            send_command(dir_rows[row].cmd, dir_rows[row].key, dir_rows[row].idx,
                         dir_rows[row].typed, dir_rows[row].res);
            sender_pause();
        end

        // Random phases alternate between filling, balanced and draining command mixes,
        // so the table spends time full, empty and in between under both settings.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0, 1, 5: write_dup(1'b0);
                2, 3, 4: write_dup(1'b1);
                default: write_dup(1'($urandom_range(0, 1)));
            endcase
            mix = (phase % 3 == 0) ? MIX_FILL : (phase % 3 == 1) ? MIX_BALANCED : MIX_DRAIN;
            if (phase == 0 || phase == 3) hold_request = 1'b1;
            for (item = 0; item < PHASE_ITEMS; item++) begin
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:     cmd = (pick < 70) ? CMD_INSERT : (pick < 85) ? CMD_READ : CMD_REMOVE;
                    MIX_BALANCED: cmd = (pick < 40) ? CMD_INSERT : (pick < 70) ? CMD_READ : CMD_REMOVE;
                    default:      cmd = (pick < 20) ? CMD_INSERT : (pick < 45) ? CMD_READ : CMD_REMOVE;
                endcase
                send_command(cmd, pick_key(), pick_index(), 1'b0, NO_RES);
                sender_pause();
            end
        end

        i_in_valid = 1'b0;
        while (table_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d inserts, %0d reads, %0d removes and %0d unused commands.",
                 n_insert, n_read, n_remove, n_nop);
        $display("Replies seen: %0d ok, %0d table full, %0d duplicate, %0d out of range.",
                 n_ok, n_full, n_dup, n_range);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
